// File: hdl/julia_inverse_iteration_points_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the inverse-iteration point walker
// Shared concurrent assertion forms, clocked on i_clk, reset on i_rst_n.
// ----------------------------------------------------------------------------
`ifndef JULIA_INVERSE_ITERATION_POINTS_ASSERT_SVH
`define JULIA_INVERSE_ITERATION_POINTS_ASSERT_SVH

// Same-cycle implication
`define JIIP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define JIIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/jiip_pkg.sv
// ----------------------------------------------------------------------------
// jiip_pkg
// Shared types, constants and helpers of the inverse-iteration point walker.
// ----------------------------------------------------------------------------
package jiip_pkg;

    localparam int DEF_STACK_ENTRIES = 16;
    localparam int DEF_VALUE_BITS    = 32;
    localparam int DEF_COORD_BITS    = 11;
    localparam int IN_DATA_W         = 8;
    localparam int CFG_IDX_W         = 3;

    // Register reset values, the fixed-point ones in Q4.28
    localparam longint RST_C_REAL   = -64'sd104958263;
    localparam longint RST_C_IMAG   = -64'sd157571614;
    localparam longint RST_SEED_RE  = 64'sd268435456;
    localparam longint RST_SEED_IM  = 64'sd0;
    localparam longint RST_OFFSET   = 64'sd402653184;
    localparam logic [3:0]  RST_DEPTH = 4'd15;
    localparam logic [11:0] RST_SCALE = 12'd640;
    localparam logic [11:0] RST_FRAME = 12'd1920;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_REAL, CFG_C_IMAG, CFG_SEED_REAL, CFG_SEED_IMAG,
        CFG_DEPTH_LIMIT, CFG_VIEW_OFFSET, CFG_VIEW_SCALE, CFG_FRAME_SIZE
    } t_cfg_idx;

    // Commands of the shared shift-add / square-root unit
    typedef enum logic [2:0] {
        U_NOP, U_MUL_CLR, U_MUL_LD, U_MUL_STEP, U_SQ_ACC, U_SQ_LD, U_SQ_STEP
    } t_uop;

    // Rescale a Q4.28 value to Q4.f, truncating toward zero
    function automatic longint q28_fix(input longint q, input int f);
        longint r;
        if (f >= 28) begin
            r = q <<< (f - 28);
        end else if (q < 0) begin
            r = -((-q) >>> (28 - f));
        end else begin
            r = q >>> (28 - f);
        end
        return r;
    endfunction

endpackage

// File: hdl/jiip_ram.sv
// ----------------------------------------------------------------------------
// jiip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jiip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/jiip_unit.sv
// ----------------------------------------------------------------------------
// jiip_unit
// Shared iterative arithmetic: shift-add squaring into an accumulator and a
// restoring square root, one bit of multiplier or two radicand bits a cycle.
// ----------------------------------------------------------------------------
module jiip_unit
    import jiip_pkg::*;
#(
    parameter int ROOT_BITS = 34
) (
    input  logic                     i_clk,
    input  t_uop                     i_op,
    input  logic [2*ROOT_BITS-1:0]   i_operand,
    output logic [ROOT_BITS-1:0]     o_root
);

    localparam int RW = 2 * ROOT_BITS;

    logic [RW-1:0]          r_acc;
    logic [RW-1:0]          r_mcd;
    logic [ROOT_BITS-1:0]   r_mpl;
    logic [RW-1:0]          r_rad;
    logic [ROOT_BITS+1:0]   r_rem;
    logic [ROOT_BITS-1:0]   r_root;

    logic [ROOT_BITS+3:0]   rem_sh;
    logic [ROOT_BITS+3:0]   trial;
    logic                   fits;

    // Trial subtraction of one root digit
    assign rem_sh = {r_rem, r_rad[RW-1:RW-2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign fits   = rem_sh >= trial;

    // Execute one command
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            U_MUL_CLR: begin
                r_acc <= '0;
                r_mcd <= i_operand;
                r_mpl <= i_operand[ROOT_BITS-1:0];
            end
            U_MUL_LD: begin
                r_mcd <= i_operand;
                r_mpl <= i_operand[ROOT_BITS-1:0];
            end
            U_MUL_STEP: begin
                if (r_mpl[0]) begin
                    r_acc <= r_acc + r_mcd;
                end
                r_mcd <= {r_mcd[RW-2:0], 1'b0};
                r_mpl <= {1'b0, r_mpl[ROOT_BITS-1:1]};
            end
            U_SQ_ACC: begin
                r_rad  <= r_acc;
                r_rem  <= '0;
                r_root <= '0;
            end
            U_SQ_LD: begin
                r_rad  <= i_operand;
                r_rem  <= '0;
                r_root <= '0;
            end
            U_SQ_STEP: begin
                r_rad <= {r_rad[RW-3:0], 2'b00};
                if (fits) begin
                    r_rem  <= (ROOT_BITS+2)'(rem_sh - trial);
                    r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[ROOT_BITS+1:0];
                    r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_root = r_root;

endmodule

// File: hdl/jiip_pix.sv
// ----------------------------------------------------------------------------
// jiip_pix
// Map a scaled coordinate product to a pixel index: truncate toward zero,
// saturate to the frame and flag anything outside it.
// ----------------------------------------------------------------------------
module jiip_pix #(
    parameter int VALUE_BITS = 32,
    parameter int COORD_BITS = 11
) (
    input  logic signed [VALUE_BITS+13:0] i_prod,
    input  logic [COORD_BITS:0]           i_limit,
    output logic [COORD_BITS-1:0]         o_pix,
    output logic                          o_off
);

    localparam int PW = VALUE_BITS + 14;
    localparam int F  = VALUE_BITS - 4;
    localparam int QW = PW - F;

    logic [PW-1:0] mag;
    logic [QW-1:0] q;
    logic [COORD_BITS:0] lim_m1;

    assign mag    = i_prod[PW-1] ? PW'(-i_prod) : PW'(i_prod);
    assign q      = mag[PW-1:F];
    assign lim_m1 = i_limit - 1'b1;

    // Clamp below zero, above the frame, else pass
    always_comb begin
        if (i_prod[PW-1]) begin
            o_pix = '0;
            o_off = |q;
        end else if (q >= QW'(i_limit)) begin
            o_pix = lim_m1[COORD_BITS-1:0];
            o_off = 1'b1;
        end else begin
            o_pix = q[COORD_BITS-1:0];
            o_off = 1'b0;
        end
    end

endmodule

// File: hdl/julia_inverse_iteration_points.sv
// ----------------------------------------------------------------------------
// julia_inverse_iteration_points
// Depth-first walker of the inverse-image tree of z -> z*z + c on a stack.
// ----------------------------------------------------------------------------
// A restart transfer (tdata bit 0 high) empties the stack and seeds the start
// point. Each advance transfer pops one point and returns its pixel column,
// row and level; a point that spawns two preimages computes them on the one
// shared shift-add / square-root unit: two squarings of VALUE_BITS+1 steps
// and three square roots of VALUE_BITS+2 steps, run back to back. An advance
// on an empty stack returns nothing. A finished result waits in the output
// register while the next transfer is taken.
module julia_inverse_iteration_points
    import jiip_pkg::*;
#(
    parameter int STACK_ENTRIES = DEF_STACK_ENTRIES,
    parameter int VALUE_BITS    = DEF_VALUE_BITS,
    parameter int COORD_BITS    = DEF_COORD_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [VALUE_BITS-1:0]    i_cfg_data,
    // input stream
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]     i_s_axis_tdata,  // [0] restart
    // output stream
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [((2*COORD_BITS+4+7)/8)*8-1:0] o_m_axis_tdata,
                                     // pixel_col, pixel_row, point_level
    output logic                     o_m_axis_tlast,  // walk_done
    output logic                     o_m_axis_tuser   // off_frame
);

    localparam int V     = VALUE_BITS;
    localparam int C     = COORD_BITS;
    localparam int F     = V - 4;
    localparam int W     = V + 1;
    localparam int K     = V + 2;
    localparam int RW    = 2 * K;
    localparam int EW    = 2 * V + 4;
    localparam int PW    = V + 14;
    localparam int CW    = $clog2(STACK_ENTRIES + 1);
    localparam int AW    = $clog2(STACK_ENTRIES);
    localparam int SW    = $clog2(K);
    localparam int OUT_W = ((2 * C + 4 + 7) / 8) * 8;
    localparam int LMW   = (C >= 12) ? C + 2 : 13;

    typedef enum logic [4:0] {
        S_IDLE, S_POP, S_LOAD, S_PIXX, S_PIXY, S_PIXD,
        S_MULA, S_LDB, S_MULB, S_LDS1, S_SQ1, S_LDS2, S_SQ2,
        S_LDS3, S_SQ3, S_PUSHP, S_PUSHN, S_EMIT
    } t_state;

    // configuration
    logic signed [V-1:0] r_c_re, r_c_im, r_seed_re, r_seed_im, r_off;
    logic [3:0]          r_depth;
    logic [11:0]         r_scale, r_frame;

    // sequencer and datapath
    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [SW-1:0]       r_step;
    logic signed [V-1:0] r_zr, r_zi, r_wr, r_wi;
    logic [3:0]          r_lvl;
    logic signed [V:0]   r_a, r_b;
    logic signed [PW-1:0] r_prod;
    logic [K-1:0]        r_rt;
    logic [C-1:0]        r_col, r_row;
    logic                r_offx, r_offf;

    // output register
    logic                r_out_valid;
    logic [C-1:0]        r_o_col, r_o_row;
    logic [3:0]          r_o_lvl;
    logic                r_o_off, r_o_done;

    logic                in_xfer, out_free, spawn, has_room;
    logic [CW-1:0]       count_dec;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [EW-1:0]       ram_wdata, ram_rdata;
    t_uop                u_op;
    logic [RW-1:0]       u_operand;
    logic [K-1:0]        u_root;
    logic [W-1:0]        ua, ub;
    logic [K+1:0]        sum_p, sum_m, rad_src;
    logic [RW-1:0]       radicand;
    logic signed [V-1:0] wi_now;
    logic signed [V:0]   pix_sum;
    logic signed [V-1:0] pix_coord;
    logic signed [12:0]  pix_sc;
    logic signed [PW-1:0] pix_prod;
    logic [C-1:0]        pix_val;
    logic                pix_off;
    logic [LMW-1:0]      frame_ext;
    logic [C:0]          limit;

    assign in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign spawn     = r_lvl < r_depth;
    assign has_room  = r_count < CW'(STACK_ENTRIES);
    assign count_dec = r_count - 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_re    <= V'(q28_fix(RST_C_REAL, F));
            r_c_im    <= V'(q28_fix(RST_C_IMAG, F));
            r_seed_re <= V'(q28_fix(RST_SEED_RE, F));
            r_seed_im <= V'(q28_fix(RST_SEED_IM, F));
            r_depth   <= RST_DEPTH;
            r_off     <= V'(q28_fix(RST_OFFSET, F));
            r_scale   <= RST_SCALE;
            r_frame   <= RST_FRAME;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_C_REAL:      r_c_re    <= i_cfg_data;
                CFG_C_IMAG:      r_c_im    <= i_cfg_data;
                CFG_SEED_REAL:   r_seed_re <= i_cfg_data;
                CFG_SEED_IMAG:   r_seed_im <= i_cfg_data;
                CFG_DEPTH_LIMIT: r_depth   <= i_cfg_data[3:0];
                CFG_VIEW_OFFSET: r_off     <= i_cfg_data;
                CFG_VIEW_SCALE:  r_scale   <= i_cfg_data[11:0];
                CFG_FRAME_SIZE:  r_frame   <= i_cfg_data[11:0];
                default:         r_depth   <= r_depth;
            endcase
        end
    end

    // Frame limit clamped to 1 .. 2^C
    assign frame_ext = LMW'(r_frame);
    always_comb begin
        if (frame_ext == '0) begin
            limit = (C+1)'(1);
        end else if (frame_ext > (LMW'(1) << C)) begin
            limit = (C+1)'(1) << C;
        end else begin
            limit = frame_ext[C:0];
        end
    end

    // Pixel product: one multiplier shared by both coordinates
    assign pix_coord = (r_state == S_PIXX) ? r_zr : r_zi;
    assign pix_sum   = {pix_coord[V-1], pix_coord} + {r_off[V-1], r_off};
    assign pix_sc    = {1'b0, r_scale};
    assign pix_prod  = PW'(pix_sum) * PW'(pix_sc);

    jiip_pix #(
        .VALUE_BITS (V),
        .COORD_BITS (C)
    ) u_pix (
        .i_prod  (r_prod),
        .i_limit (limit),
        .o_pix   (pix_val),
        .o_off   (pix_off)
    );

    // Operands of the shared unit
    assign ua       = r_a[V] ? W'(-r_a) : W'(r_a);
    assign ub       = r_b[V] ? W'(-r_b) : W'(r_b);
    assign sum_p    = {2'b00, u_root} + {{3{r_a[V]}}, r_a};
    assign sum_m    = {2'b00, r_rt} - {{3{r_a[V]}}, r_a};
    assign rad_src  = (r_state == S_LDS2) ? sum_p : sum_m;
    assign radicand = RW'(rad_src) << (F - 1);
    assign wi_now   = r_b[V] ? -$signed(u_root[V-1:0]) : $signed(u_root[V-1:0]);

    always_comb begin
        u_op      = U_NOP;
        u_operand = RW'(ua);
        unique case (r_state)
            S_PIXD:  u_op = spawn ? U_MUL_CLR : U_NOP;
            S_MULA:  u_op = U_MUL_STEP;
            S_LDB: begin
                u_op      = U_MUL_LD;
                u_operand = RW'(ub);
            end
            S_MULB:  u_op = U_MUL_STEP;
            S_LDS1:  u_op = U_SQ_ACC;
            S_LDS2, S_LDS3: begin
                u_op      = U_SQ_LD;
                u_operand = radicand;
            end
            S_SQ1, S_SQ2, S_SQ3: u_op = U_SQ_STEP;
            default: u_op = U_NOP;
        endcase
    end

    jiip_unit #(
        .ROOT_BITS (K)
    ) u_unit (
        .i_clk     (i_clk),
        .i_op      (u_op),
        .i_operand (u_operand),
        .o_root    (u_root)
    );

    // Stack writes: seed on restart, the two preimages after the roots
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = {r_lvl + 4'd1, r_wi, r_wr};
        unique case (r_state)
            S_IDLE: begin
                ram_we    = in_xfer && i_s_axis_tdata[0];
                ram_waddr = '0;
                ram_wdata = {4'd0, r_seed_im, r_seed_re};
            end
            S_PUSHP: begin
                ram_we    = has_room;
                ram_wdata = {r_lvl + 4'd1, wi_now, r_wr};
            end
            S_PUSHN: begin
                ram_we    = has_room;
                ram_wdata = {r_lvl + 4'd1, -r_wi, -r_wr};
            end
            default: ram_we = 1'b0;
        endcase
    end

    assign ram_raddr = count_dec[AW-1:0];

    jiip_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_ENTRIES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop a taken result unless a new one replaces it this cycle
            if (r_out_valid && i_m_axis_tready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_s_axis_tdata[0]) begin
                            r_count <= CW'(1);
                        end else begin
                            r_state <= S_POP;
                        end
                    end
                end
                S_POP: begin
                    if (r_count == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_count <= count_dec;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_zr    <= ram_rdata[V-1:0];
                    r_zi    <= ram_rdata[2*V-1:V];
                    r_lvl   <= ram_rdata[EW-1:2*V];
                    r_state <= S_PIXX;
                end
                S_PIXX: begin
                    r_prod  <= pix_prod;
                    r_a     <= {r_zr[V-1], r_zr} - {r_c_re[V-1], r_c_re};
                    r_b     <= {r_zi[V-1], r_zi} - {r_c_im[V-1], r_c_im};
                    r_state <= S_PIXY;
                end
                S_PIXY: begin
                    r_col   <= pix_val;
                    r_offx  <= pix_off;
                    r_prod  <= pix_prod;
                    r_state <= S_PIXD;
                end
                S_PIXD: begin
                    r_row   <= pix_val;
                    r_offf  <= r_offx | pix_off;
                    r_step  <= '0;
                    r_state <= spawn ? S_MULA : S_EMIT;
                end
                S_MULA: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(W - 1)) begin
                        r_state <= S_LDB;
                    end
                end
                S_LDB: begin
                    r_step  <= '0;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(W - 1)) begin
                        r_state <= S_LDS1;
                    end
                end
                S_LDS1: begin
                    r_step  <= '0;
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(K - 1)) begin
                        r_state <= S_LDS2;
                    end
                end
                S_LDS2: begin
                    r_rt    <= u_root;
                    r_step  <= '0;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(K - 1)) begin
                        r_state <= S_LDS3;
                    end
                end
                S_LDS3: begin
                    r_wr    <= u_root[V-1:0];
                    r_step  <= '0;
                    r_state <= S_SQ3;
                end
                S_SQ3: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(K - 1)) begin
                        r_state <= S_PUSHP;
                    end
                end
                S_PUSHP: begin
                    r_wi <= wi_now;
                    if (has_room) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_PUSHN;
                end
                S_PUSHN: begin
                    if (has_room) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_col     <= r_col;
                        r_o_row     <= r_row;
                        r_o_lvl     <= r_lvl;
                        r_o_off     <= r_offf;
                        r_o_done    <= r_count == '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_o_lvl, r_o_row, r_o_col});
    assign o_m_axis_tlast  = r_o_done;
    assign o_m_axis_tuser  = r_o_off;

endmodule

// File: hdl/jiip_checker.sv
// ----------------------------------------------------------------------------
// jiip_checker
// Port-level checks of the point walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "julia_inverse_iteration_points_assert.svh"

module jiip_checker #(
    parameter int OUT_W = 32
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic [7:0]       i_s_axis_tdata,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tlast,
    input logic             o_m_axis_tuser
);

    // Hold a stalled result
    `JIIP_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))

    // An advance occupies the walker in the next cycle
    `JIIP_ASSERT_NEXT(a_busy_after_advance, i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tdata[0], !o_s_axis_tready)

    // A restart completes in its own cycle
    `JIIP_ASSERT_NEXT(a_restart_quick, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tdata[0], o_s_axis_tready)

    // A new result only follows a busy cycle
    `JIIP_ASSERT_IMPL(a_result_after_work, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready))

endmodule

bind julia_inverse_iteration_points jiip_checker #(.OUT_W(OUT_W)) u_jiip_checker (.*);
